>>> hdl/time_slice_task_scheduler_core_macros.svh
// Assertion macros used by the scheduler checker.
// Expects clk and arst_n in the scope of each use.
`ifndef TIME_SLICE_TASK_SCHEDULER_CORE_MACROS_SVH
`define TIME_SLICE_TASK_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication.
`define TSTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication.
`define TSTS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

>>> hdl/tsts_pkg.sv
// Shared types, constants and helper functions of the time-slice scheduler.
// No dependencies.
package tsts_pkg;

	localparam int TASK_COUNT = 8;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = $clog2(TASK_COUNT);

	localparam int TASK_W     = 3;
	localparam int VALUE_W    = 16;
	localparam int SEED_W     = 16;
	localparam int LEFT_W     = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

	localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL_SEED = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_WR_PRIO = 2'd1,
		OP_WR_CNT  = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SDRAIN,
		S_REFILL,
		S_RDRAIN,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                  rd_en;
		logic [IDX_W-1:0]      rd_addr;
		logic                  cnt_we;
		logic                  pri_we;
		logic [IDX_W-1:0]      wr_addr;
		logic [COUNT_BITS-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic              mode;
		logic              seed_ld;
		logic [SEED_W-1:0] seed;
	} cfg_t;

	typedef struct packed {
		logic [TASK_W-1:0] running_task;
		logic              rescheduled;
		logic              task_changed;
		logic              refilled;
		logic [LEFT_W-1:0] slice_left;
	} result_t;

	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
		lfsr_step = {1'b0, v[SEED_W-1:1]} ^ (v[0] ? LFSR_TAPS : '0);
	endfunction

	function automatic logic [COUNT_BITS-1:0] prio_refill(
		input logic [COUNT_BITS-1:0] cnt,
		input logic [COUNT_BITS-1:0] pri
	);
		logic [COUNT_BITS:0] sum;
		sum = {2'b00, cnt[COUNT_BITS-1:1]} + {1'b0, pri};
		prio_refill = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
	endfunction

endpackage

>>> hdl/tsts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/tsts_seq.sv
// Scheduling sequencer: scan, refill and update of the task tables in RAM.
// Depends on tsts_pkg.
module tsts_seq
	import tsts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  start,
	input  op_t                   op_in,
	input  logic [TASK_W-1:0]     idx_in,
	input  logic [VALUE_W-1:0]    val_in,
	output logic                  in_ready,
	input  logic [COUNT_BITS-1:0] cnt_rdata,
	input  logic [COUNT_BITS-1:0] pri_rdata,
	output mem_req_t              mreq,
	input  logic                  out_free,
	output logic                  res_valid,
	output result_t               res
);

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TASK_COUNT - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      run_q, before_q, scan_k_q, best_q, rd_idx_s1;
	logic [COUNT_BITS-1:0] best_val_q;
	logic                  refl_q, resched_q;
	logic                  rd_pend_s1, rd_cvld_s1, rd_pvld_s1;
	logic [TASK_COUNT-1:0] cnt_vld_q, pri_vld_q;
	logic [SEED_W-1:0]     lfsr_q, lfsr_nxt;

	logic [COUNT_BITS-1:0] cnt_rd, pri_rd, refill_val, best_val_nxt;
	logic [IDX_W-1:0]      best_nxt;
	logic                  cand_ok, wr_ok, run_live, go_refill, lfsr_adv;

	assign cnt_rd   = rd_cvld_s1 ? cnt_rdata : '0;
	assign pri_rd   = rd_pvld_s1 ? pri_rdata : '0;
	assign lfsr_nxt = lfsr_step(lfsr_q);

	assign cand_ok = rd_pend_s1 && (cnt_rd != '0) &&
		((best_q == '0) || (cfg.mode ? (cnt_rd > best_val_q) : (cnt_rd < best_val_q)));
	assign best_nxt     = cand_ok ? rd_idx_s1 : best_q;
	assign best_val_nxt = cand_ok ? cnt_rd : best_val_q;

	assign refill_val = cfg.mode ? prio_refill(cnt_rd, pri_rd) : COUNT_BITS'(lfsr_nxt);
	assign wr_ok      = (idx_in != '0) && (32'(idx_in) < TASK_COUNT);
	assign run_live   = (run_q != '0) && (cnt_rd != '0);
	assign go_refill  = (best_nxt == '0) && !refl_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (op_in == OP_TICK) ? S_CHECK : S_FIN;
				end
			end
			S_CHECK:  state_d = run_live ? S_FIN : S_SCAN;
			S_SCAN: begin
				if (scan_k_q == LAST_IDX) begin
					state_d = S_SDRAIN;
				end
			end
			S_SDRAIN: state_d = go_refill ? S_REFILL : S_FIN;
			S_REFILL: begin
				if (scan_k_q == LAST_IDX) begin
					state_d = S_RDRAIN;
				end
			end
			S_RDRAIN: state_d = S_SCAN;
			S_FIN:    state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mreq         = '0;
		mreq.rd_addr = run_q;
		in_ready     = 1'b0;
		res_valid    = 1'b0;
		lfsr_adv     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				mreq.rd_en = start && (op_in == OP_TICK);
				if (start && wr_ok) begin
					mreq.cnt_we  = (op_in == OP_WR_CNT);
					mreq.pri_we  = (op_in == OP_WR_PRIO);
					mreq.wr_addr = IDX_W'(idx_in);
					mreq.wr_data = COUNT_BITS'(val_in);
				end
			end
			S_CHECK: begin
				if (run_live) begin
					mreq.cnt_we  = 1'b1;
					mreq.wr_addr = run_q;
					mreq.wr_data = cnt_rd - COUNT_BITS'(1);
				end
			end
			S_SCAN: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = scan_k_q;
			end
			S_SDRAIN: begin
				if (!go_refill && (best_nxt != '0)) begin
					mreq.cnt_we  = 1'b1;
					mreq.wr_addr = best_nxt;
					mreq.wr_data = best_val_nxt - COUNT_BITS'(1);
				end
			end
			S_REFILL: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = scan_k_q;
				if (rd_pend_s1) begin
					mreq.cnt_we  = 1'b1;
					mreq.wr_addr = rd_idx_s1;
					mreq.wr_data = refill_val;
					lfsr_adv     = !cfg.mode;
				end
			end
			S_RDRAIN: begin
				mreq.cnt_we  = 1'b1;
				mreq.wr_addr = rd_idx_s1;
				mreq.wr_data = refill_val;
				lfsr_adv     = !cfg.mode;
			end
			S_FIN: begin
				mreq.rd_en = 1'b1;
			end
			S_OUT: begin
				res_valid = out_free;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.running_task = TASK_W'(run_q);
		res.rescheduled  = resched_q;
		res.task_changed = (run_q != before_q);
		res.refilled     = refl_q;
		res.slice_left   = (32'(cnt_rd) > 32'(16'hFFFF)) ? '1 : LEFT_W'(cnt_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			run_q      <= '0;
			cnt_vld_q  <= '0;
			pri_vld_q  <= '0;
			lfsr_q     <= SEED_W'(1);
			rd_pend_s1 <= 1'b0;
			rd_cvld_s1 <= 1'b0;
			rd_pvld_s1 <= 1'b0;
			refl_q     <= 1'b0;
			resched_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= mreq.rd_en && (state_q == S_SCAN || state_q == S_REFILL);
			if (mreq.rd_en) begin
				rd_cvld_s1 <= cnt_vld_q[mreq.rd_addr];
				rd_pvld_s1 <= pri_vld_q[mreq.rd_addr];
			end
			if (mreq.cnt_we) begin
				cnt_vld_q[mreq.wr_addr] <= 1'b1;
			end
			if (mreq.pri_we) begin
				pri_vld_q[mreq.wr_addr] <= 1'b1;
			end
			if (cfg.seed_ld) begin
				lfsr_q <= (cfg.seed != '0) ? cfg.seed : SEED_W'(1);
			end else if (lfsr_adv) begin
				lfsr_q <= lfsr_nxt;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						refl_q    <= 1'b0;
						resched_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (!run_live) begin
						resched_q <= 1'b1;
					end
				end
				S_SDRAIN: begin
					if (go_refill) begin
						refl_q <= 1'b1;
					end else begin
						run_q <= best_nxt;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= mreq.rd_addr;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					before_q <= run_q;
				end
			end
			S_CHECK, S_RDRAIN: begin
				scan_k_q   <= FIRST_IDX;
				best_q     <= '0;
				best_val_q <= '0;
			end
			S_SCAN: begin
				scan_k_q   <= scan_k_q + IDX_W'(1);
				best_q     <= best_nxt;
				best_val_q <= best_val_nxt;
			end
			S_SDRAIN: begin
				scan_k_q   <= FIRST_IDX;
				best_q     <= best_nxt;
				best_val_q <= best_val_nxt;
			end
			S_REFILL: begin
				scan_k_q <= scan_k_q + IDX_W'(1);
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/time_slice_task_scheduler_core.sv
// Time-slice task scheduler top level: stream ports, configuration, task RAMs.
// Depends on tsts_pkg, tsts_ram and tsts_seq.
//
//   channel   signals                         moves
//   s_*       s_tvalid s_tready s_tdata s_tuser  one command per transfer
//   m_*       m_tvalid m_tready m_tdata m_tuser  one result per command
//   cfg_*     cfg_we cfg_index cfg_wdata       register write, no handshake
//
// Writes and no-ops pass through S_IDLE, S_FIN and S_OUT; a tick that only
// decrements also passes S_CHECK. A tick that reschedules scans the count
// RAM one entry a cycle; if no task has a nonzero count, a refill pass
// (S_REFILL, S_RDRAIN) rewrites the counts and the scan runs again. A new
// command is taken once the result is in the output register; a stalled result
// holds the sequencer. Reset clears the tables through per-entry valid bits.
module time_slice_task_scheduler_core
	import tsts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // task_index[2:0], write_value[18:3], zero pad
	input  logic [1:0]           s_tuser,   // opcode[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // running_task[2:0], slice_left[18:3], zero pad
	output logic [2:0]           m_tuser    // rescheduled[0], task_changed[1], refilled[2]
);

	cfg_t                  cfg;
	logic                  mode_q;
	logic                  start, in_ready, out_free, res_valid;
	mem_req_t              mreq;
	result_t               res, res_q;
	logic [COUNT_BITS-1:0] cnt_rdata, pri_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we && cfg_index == CFG_SCHED_MODE) begin
			mode_q <= cfg_wdata[0];
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.seed_ld = cfg_we && (cfg_index == CFG_REFILL_SEED);
	assign cfg.seed    = cfg_wdata;

	assign s_tready = in_ready;
	assign start    = s_tvalid && in_ready;
	assign out_free = !m_tvalid || m_tready;

	tsts_ram #(.WIDTH(COUNT_BITS), .DEPTH(TASK_COUNT)) u_cnt_ram (
		.clk   (clk),
		.we    (mreq.cnt_we),
		.waddr (mreq.wr_addr),
		.wdata (mreq.wr_data),
		.re    (mreq.rd_en),
		.raddr (mreq.rd_addr),
		.rdata (cnt_rdata)
	);

	tsts_ram #(.WIDTH(COUNT_BITS), .DEPTH(TASK_COUNT)) u_pri_ram (
		.clk   (clk),
		.we    (mreq.pri_we),
		.waddr (mreq.wr_addr),
		.wdata (mreq.wr_data),
		.re    (mreq.rd_en),
		.raddr (mreq.rd_addr),
		.rdata (pri_rdata)
	);

	tsts_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.op_in     (op_t'(s_tuser)),
		.idx_in    (s_tdata[2:0]),
		.val_in    (s_tdata[18:3]),
		.in_ready  (in_ready),
		.cnt_rdata (cnt_rdata),
		.pri_rdata (pri_rdata),
		.mreq      (mreq),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tdata = {5'b0, res_q.slice_left, res_q.running_task};
	assign m_tuser = {res_q.refilled, res_q.task_changed, res_q.rescheduled};

endmodule

>>> hdl/tsts_chk.sv
// Port-level checker for the scheduler core, bound to the top level.
// Depends on time_slice_task_scheduler_core_macros.svh.
`include "time_slice_task_scheduler_core_macros.svh"

module tsts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	`TSTS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`TSTS_ASSERT_IMP(a_idle_empty, m_tvalid && m_tdata[2:0] == 3'd0, m_tdata[18:3] == 16'd0)
	`TSTS_ASSERT_IMP(a_change_resched, m_tvalid && m_tuser[1], m_tuser[0])
	`TSTS_ASSERT_IMP(a_refill_resched, m_tvalid && m_tuser[2], m_tuser[0])

endmodule

bind time_slice_task_scheduler_core tsts_chk u_tsts_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
